FILE: rtl/srtf_pkg.sv
// Shared types and constants for the shortest-remaining-time scheduler.
// No dependencies; imported by srtf_fsm, srtf_dp, the top level and the testbench.
`default_nettype none

package srtf_pkg;

   // default sizes of the slot tables and the clock
   localparam int MAX_PROCESSES_DEF = 16;
   localparam int TIME_BITS_DEF     = 16;

   // fixed widths of the port fields
   localparam int OPCODE_BITS = 1;
   localparam int SLOT_BITS   = 4;
   localparam int FIELD_BITS  = 16;
   localparam int OUT_BITS    = 16;
   localparam int PID_BITS    = 5;
   localparam int COUNT_BITS  = 5;

   // opcodes of a request word
   localparam logic [OPCODE_BITS-1:0] OP_LOAD = 1'b0;
   localparam logic [OPCODE_BITS-1:0] OP_TICK = 1'b1;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SCAN,
      ST_DRAIN,
      ST_DECIDE,
      ST_FINISH
   } state_type;

   // sequencer to datapath
   typedef struct packed {
      logic load;
      logic tick_start;
      logic rd_en;
      logic decide;
      logic finish;
   } ctrl_type;

   // datapath to sequencer
   typedef struct packed {
      logic finishing;
   } stat_type;

endpackage : srtf_pkg

`default_nettype wire

FILE: rtl/srtf_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
`default_nettype none

module srtf_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 16,
   localparam int ADDR_BITS = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  wire logic                 clock,
   input  wire logic                 wr_en,
   input  wire logic [ADDR_BITS-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]     wr_data,
   input  wire logic                 rd_en,
   input  wire logic [ADDR_BITS-1:0] rd_addr,
   output      logic [WIDTH-1:0]     rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule : srtf_ram

`default_nettype wire

FILE: rtl/srtf_fsm.sv
// Sequencer of the scheduler: accepts commands, walks the slot index during
// a tick and steps the datapath through decide and finish. Uses srtf_pkg.
`default_nettype none

module srtf_fsm #(
   parameter int MAX_PROCESSES = srtf_pkg::MAX_PROCESSES_DEF,
   localparam int IDX_BITS = $clog2(MAX_PROCESSES)
) (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire logic                             start,
   input  wire logic [srtf_pkg::OPCODE_BITS-1:0] opcode,
   input  wire logic [srtf_pkg::SLOT_BITS-1:0]   slot,
   input  wire logic [srtf_pkg::COUNT_BITS-1:0]  num_processes,
   input  wire srtf_pkg::stat_type               stat,
   output      logic                             busy,
   output      srtf_pkg::ctrl_type               ctrl,
   output      logic [IDX_BITS-1:0]              scan_addr
);

   import srtf_pkg::*;

   localparam int CNT_BITS = $clog2(MAX_PROCESSES + 1);

   state_type            state_ff, state_in;
   logic [CNT_BITS-1:0]  idx_ff, idx_in;
   logic [CNT_BITS-1:0]  active;
   logic                 scan_last;
   logic                 slot_ok;
   logic                 idle;

   // counts above the table size act as the table size
   assign active = (32'(num_processes) > 32'(MAX_PROCESSES)) ?
                   CNT_BITS'(MAX_PROCESSES) : CNT_BITS'(num_processes);
   assign scan_last = ({1'b0, idx_ff} + (CNT_BITS + 1)'(1)) >= {1'b0, active};
   assign slot_ok   = 32'(slot) < 32'(MAX_PROCESSES);
   assign idle      = (state_ff == ST_IDLE);
   assign scan_addr = idx_ff[IDX_BITS-1:0];

   always_comb begin
      state_in = state_ff;
      idx_in   = idx_ff;
      case (state_ff)
         ST_IDLE: begin
            if (start && opcode == OP_TICK) begin
               state_in = ST_SCAN;
               idx_in   = '0;
            end
         end
         ST_SCAN: begin
            idx_in = idx_ff + CNT_BITS'(1);
            if (scan_last) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN:  state_in = ST_DECIDE;
         ST_DECIDE: state_in = stat.finishing ? ST_FINISH : ST_IDLE;
         ST_FINISH: state_in = ST_IDLE;
         default:   state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      busy            = !idle;
      ctrl.load       = idle && start && (opcode == OP_LOAD) && slot_ok;
      ctrl.tick_start = idle && start && (opcode == OP_TICK);
      ctrl.rd_en      = (state_ff == ST_SCAN) && (idx_ff < active);
      ctrl.decide     = (state_ff == ST_DECIDE);
      ctrl.finish     = (state_ff == ST_FINISH);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         idx_ff   <= '0;
      end else begin
         state_ff <= state_in;
         idx_ff   <= idx_in;
      end
   end

endmodule : srtf_fsm

`default_nettype wire

FILE: rtl/srtf_dp.sv
// Datapath of the scheduler: slot valid bits, the clock, the running best
// candidate, the shared subtractor and the result word. Uses srtf_pkg.
`default_nettype none

module srtf_dp #(
   parameter int MAX_PROCESSES = srtf_pkg::MAX_PROCESSES_DEF,
   parameter int TIME_BITS     = srtf_pkg::TIME_BITS_DEF,
   localparam int IDX_BITS = $clog2(MAX_PROCESSES)
) (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire srtf_pkg::ctrl_type             ctrl,
   output      srtf_pkg::stat_type             stat,
   input  wire logic [IDX_BITS-1:0]            scan_addr,
   input  wire logic [IDX_BITS-1:0]            load_addr,
   input  wire logic [TIME_BITS-1:0]           rd_arrival,
   input  wire logic [TIME_BITS-1:0]           rd_remaining,
   input  wire logic [TIME_BITS-1:0]           rd_burst,
   output      logic [IDX_BITS-1:0]            best_idx,
   output      logic                           rem_dec_en,
   output      logic [TIME_BITS-1:0]           rem_dec_data,
   output      logic                           rsp_valid,
   output      logic                           rsp_ran,
   output      logic [srtf_pkg::PID_BITS-1:0]  rsp_process_id,
   output      logic                           rsp_finished,
   output      logic [srtf_pkg::OUT_BITS-1:0]  rsp_wait_time,
   output      logic [srtf_pkg::OUT_BITS-1:0]  rsp_turnaround,
   output      logic                           rsp_all_done,
   output      logic [srtf_pkg::OUT_BITS-1:0]  rsp_tick_time
);

   import srtf_pkg::*;

   // room for completion minus arrival plus a borrow bit
   localparam int SUB_BITS = TIME_BITS + 2;
   localparam int EXT_BITS = (SUB_BITS > OUT_BITS + 1) ? SUB_BITS : OUT_BITS + 1;

   function automatic logic [OUT_BITS-1:0] sat_out(input logic [SUB_BITS-1:0] v);
      logic [EXT_BITS-1:0] ext;
      ext = EXT_BITS'(v);
      return ((ext >> OUT_BITS) != '0) ? '1 : OUT_BITS'(ext);
   endfunction

   logic [MAX_PROCESSES-1:0] valid_ff, valid_in;
   logic [TIME_BITS-1:0]     time_ff, time_in;
   logic                     pend_ff, pend_in;
   logic [IDX_BITS-1:0]      pend_idx_ff, pend_idx_in;
   logic                     pend_vld_ff, pend_vld_in;
   logic                     any_left_ff, any_left_in;
   logic                     found_ff, found_in;
   logic [IDX_BITS-1:0]      best_idx_ff, best_idx_in;
   logic [TIME_BITS-1:0]     best_rem_ff, best_rem_in;
   logic [TIME_BITS-1:0]     best_arr_ff, best_arr_in;
   logic [SUB_BITS-1:0]      tat_ff, tat_in;

   logic                     rsp_valid_ff, rsp_valid_in;
   logic                     rsp_ran_ff, rsp_ran_in;
   logic [PID_BITS-1:0]      rsp_pid_ff, rsp_pid_in;
   logic                     rsp_finished_ff, rsp_finished_in;
   logic [OUT_BITS-1:0]      rsp_wait_ff, rsp_wait_in;
   logic [OUT_BITS-1:0]      rsp_turn_ff, rsp_turn_in;
   logic                     rsp_all_done_ff, rsp_all_done_in;
   logic [OUT_BITS-1:0]      rsp_tick_ff, rsp_tick_in;

   logic [TIME_BITS-1:0]     cand_rem;
   logic                     cand_live;
   logic                     cand_take;
   logic [SUB_BITS-1:0]      sub_a, sub_b, sub_diff;
   logic [SUB_BITS-1:0]      wait_val;
   logic                     finishing;
   logic                     advance;
   logic [PID_BITS-1:0]      best_pid;

   // evaluate the slot whose read data has just arrived
   always_comb begin
      cand_rem  = pend_vld_ff ? rd_remaining : '0;
      cand_live = pend_ff && (cand_rem != '0);
      cand_take = cand_live && (rd_arrival <= time_ff) &&
                  (!found_ff || (cand_rem < best_rem_ff));
   end

   // shared subtractor: turnaround on decide, waiting time on finish
   always_comb begin
      if (ctrl.finish) begin
         sub_a = tat_ff;
         sub_b = SUB_BITS'(rd_burst);
      end else begin
         sub_a = SUB_BITS'(time_ff) + SUB_BITS'(1);
         sub_b = SUB_BITS'(best_arr_ff);
      end
      sub_diff = sub_a - sub_b;
      wait_val = sub_diff[SUB_BITS-1] ? '0 : sub_diff;
   end

   assign finishing = any_left_ff && found_ff && (best_rem_ff == TIME_BITS'(1));
   assign advance   = (ctrl.decide && any_left_ff && !finishing) || ctrl.finish;
   assign best_pid  = PID_BITS'(best_idx_ff) + PID_BITS'(1);

   always_comb begin
      valid_in    = valid_ff;
      time_in     = time_ff;
      pend_in     = ctrl.rd_en;
      pend_idx_in = scan_addr;
      pend_vld_in = valid_ff[scan_addr];
      any_left_in = any_left_ff;
      found_in    = found_ff;
      best_idx_in = best_idx_ff;
      best_rem_in = best_rem_ff;
      best_arr_in = best_arr_ff;
      tat_in      = ctrl.decide ? sub_diff : tat_ff;

      if (ctrl.load) begin
         valid_in[load_addr] = 1'b1;
         time_in             = '0;
      end else if (advance && (time_ff != '1)) begin
         time_in = time_ff + TIME_BITS'(1);
      end

      if (ctrl.tick_start) begin
         any_left_in = 1'b0;
         found_in    = 1'b0;
      end else begin
         if (cand_live) begin
            any_left_in = 1'b1;
         end
         if (cand_take) begin
            found_in    = 1'b1;
            best_idx_in = pend_idx_ff;
            best_rem_in = cand_rem;
            best_arr_in = rd_arrival;
         end
      end
   end

   always_comb begin
      rsp_valid_in    = 1'b0;
      rsp_ran_in      = rsp_ran_ff;
      rsp_pid_in      = rsp_pid_ff;
      rsp_finished_in = rsp_finished_ff;
      rsp_wait_in     = rsp_wait_ff;
      rsp_turn_in     = rsp_turn_ff;
      rsp_all_done_in = rsp_all_done_ff;
      rsp_tick_in     = rsp_tick_ff;
      if (ctrl.decide && !finishing) begin
         rsp_valid_in    = 1'b1;
         rsp_ran_in      = any_left_ff && found_ff;
         rsp_pid_in      = (any_left_ff && found_ff) ? best_pid : '0;
         rsp_finished_in = 1'b0;
         rsp_wait_in     = '0;
         rsp_turn_in     = '0;
         rsp_all_done_in = !any_left_ff;
         rsp_tick_in     = OUT_BITS'(time_ff);
      end else if (ctrl.finish) begin
         rsp_valid_in    = 1'b1;
         rsp_ran_in      = 1'b1;
         rsp_pid_in      = best_pid;
         rsp_finished_in = 1'b1;
         rsp_wait_in     = sat_out(wait_val);
         rsp_turn_in     = sat_out(tat_ff);
         rsp_all_done_in = 1'b0;
         rsp_tick_in     = OUT_BITS'(time_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff     <= '0;
         time_ff      <= '0;
         pend_ff      <= 1'b0;
         any_left_ff  <= 1'b0;
         found_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         valid_ff     <= valid_in;
         time_ff      <= time_in;
         pend_ff      <= pend_in;
         any_left_ff  <= any_left_in;
         found_ff     <= found_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      pend_idx_ff     <= pend_idx_in;
      pend_vld_ff     <= pend_vld_in;
      best_idx_ff     <= best_idx_in;
      best_rem_ff     <= best_rem_in;
      best_arr_ff     <= best_arr_in;
      tat_ff          <= tat_in;
      rsp_ran_ff      <= rsp_ran_in;
      rsp_pid_ff      <= rsp_pid_in;
      rsp_finished_ff <= rsp_finished_in;
      rsp_wait_ff     <= rsp_wait_in;
      rsp_turn_ff     <= rsp_turn_in;
      rsp_all_done_ff <= rsp_all_done_in;
      rsp_tick_ff     <= rsp_tick_in;
   end

   assign stat.finishing = finishing;
   assign best_idx       = best_idx_ff;
   assign rem_dec_en     = ctrl.decide && any_left_ff && found_ff;
   assign rem_dec_data   = best_rem_ff - TIME_BITS'(1);

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_ran        = rsp_ran_ff;
   assign rsp_process_id = rsp_pid_ff;
   assign rsp_finished   = rsp_finished_ff;
   assign rsp_wait_time  = rsp_wait_ff;
   assign rsp_turnaround = rsp_turn_ff;
   assign rsp_all_done   = rsp_all_done_ff;
   assign rsp_tick_time  = rsp_tick_ff;

endmodule : srtf_dp

`default_nettype wire

FILE: rtl/shortest_remaining_time_scheduler.sv
// Top level of the shortest-remaining-time scheduler.
// Depends on srtf_pkg, srtf_ram, srtf_fsm and srtf_dp.
//
// A load word (opcode load) writes one slot's arrival and burst, arms its
// remaining time and resets the clock; it is taken in the cycle it is offered, busy stays
// low and no result word follows. A tick word raises busy and walks the
// active slots through one shared compare unit, one slot per cycle off the
// table read ports; a tick always passes through the scan state, even with
// a count of zero, then drain and decide, and finish too when the chosen
// process completes (its burst is read and the waiting time
// formed on the shared subtractor). Each tick gives exactly one result word
// on rsp_valid for a single cycle; the receiver cannot stall it, so sample
// it when it appears. A new command may be issued in the cycle the result
// shows. Write csr_wr_data (the active slot count) only while busy is low.
`default_nettype none

module shortest_remaining_time_scheduler #(
   parameter int MAX_PROCESSES = srtf_pkg::MAX_PROCESSES_DEF,
   parameter int TIME_BITS     = srtf_pkg::TIME_BITS_DEF
) (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire logic                             start,
   output      logic                             busy,
   input  wire logic [srtf_pkg::OPCODE_BITS-1:0] req_opcode,
   input  wire logic [srtf_pkg::SLOT_BITS-1:0]   req_slot,
   input  wire logic [srtf_pkg::FIELD_BITS-1:0]  req_arrival,
   input  wire logic [srtf_pkg::FIELD_BITS-1:0]  req_burst,
   input  wire logic                             csr_wr_en,
   input  wire logic [srtf_pkg::COUNT_BITS-1:0]  csr_wr_data,
   output      logic                             rsp_valid,
   output      logic                             rsp_ran,
   output      logic [srtf_pkg::PID_BITS-1:0]    rsp_process_id,
   output      logic                             rsp_finished,
   output      logic [srtf_pkg::OUT_BITS-1:0]    rsp_wait_time,
   output      logic [srtf_pkg::OUT_BITS-1:0]    rsp_turnaround,
   output      logic                             rsp_all_done,
   output      logic [srtf_pkg::OUT_BITS-1:0]    rsp_tick_time
);

   import srtf_pkg::*;

   localparam int IDX_BITS = $clog2(MAX_PROCESSES);

   logic [COUNT_BITS-1:0] num_processes_ff, num_processes_in;

   ctrl_type              ctrl;
   stat_type              stat;
   logic [IDX_BITS-1:0]   scan_addr;
   logic [IDX_BITS-1:0]   load_addr;
   logic [IDX_BITS-1:0]   best_idx;
   logic                  rem_dec_en;
   logic [TIME_BITS-1:0]  rem_dec_data;
   logic [TIME_BITS-1:0]  arrival_sat, burst_sat;
   logic [TIME_BITS-1:0]  rd_arrival, rd_remaining, rd_burst;
   logic                  rem_wr_en;
   logic [IDX_BITS-1:0]   rem_wr_addr;
   logic [TIME_BITS-1:0]  rem_wr_data;

   assign num_processes_in = csr_wr_en ? csr_wr_data : num_processes_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         num_processes_ff <= '0;
      end else begin
         num_processes_ff <= num_processes_in;
      end
   end

   // clamp load values to the clock width
   always_comb begin
      arrival_sat = ((32'(req_arrival) >> TIME_BITS) != 32'd0) ? '1 :
                    TIME_BITS'(req_arrival);
      burst_sat   = ((32'(req_burst) >> TIME_BITS) != 32'd0) ? '1 :
                    TIME_BITS'(req_burst);
   end

   assign load_addr   = IDX_BITS'(req_slot);
   assign rem_wr_en   = ctrl.load || rem_dec_en;
   assign rem_wr_addr = ctrl.load ? load_addr : best_idx;
   assign rem_wr_data = ctrl.load ? burst_sat : rem_dec_data;

   srtf_ram #(
      .WIDTH (TIME_BITS),
      .DEPTH (MAX_PROCESSES)
   ) u_arrival_ram (
      .clock   (clock),
      .wr_en   (ctrl.load),
      .wr_addr (load_addr),
      .wr_data (arrival_sat),
      .rd_en   (ctrl.rd_en),
      .rd_addr (scan_addr),
      .rd_data (rd_arrival)
   );

   srtf_ram #(
      .WIDTH (TIME_BITS),
      .DEPTH (MAX_PROCESSES)
   ) u_burst_ram (
      .clock   (clock),
      .wr_en   (ctrl.load),
      .wr_addr (load_addr),
      .wr_data (burst_sat),
      .rd_en   (ctrl.decide),
      .rd_addr (best_idx),
      .rd_data (rd_burst)
   );

   srtf_ram #(
      .WIDTH (TIME_BITS),
      .DEPTH (MAX_PROCESSES)
   ) u_remaining_ram (
      .clock   (clock),
      .wr_en   (rem_wr_en),
      .wr_addr (rem_wr_addr),
      .wr_data (rem_wr_data),
      .rd_en   (ctrl.rd_en),
      .rd_addr (scan_addr),
      .rd_data (rd_remaining)
   );

   srtf_fsm #(
      .MAX_PROCESSES (MAX_PROCESSES)
   ) u_fsm (
      .clock         (clock),
      .reset         (reset),
      .start         (start),
      .opcode        (req_opcode),
      .slot          (req_slot),
      .num_processes (num_processes_ff),
      .stat          (stat),
      .busy          (busy),
      .ctrl          (ctrl),
      .scan_addr     (scan_addr)
   );

   srtf_dp #(
      .MAX_PROCESSES (MAX_PROCESSES),
      .TIME_BITS     (TIME_BITS)
   ) u_dp (
      .clock          (clock),
      .reset          (reset),
      .ctrl           (ctrl),
      .stat           (stat),
      .scan_addr      (scan_addr),
      .load_addr      (load_addr),
      .rd_arrival     (rd_arrival),
      .rd_remaining   (rd_remaining),
      .rd_burst       (rd_burst),
      .best_idx       (best_idx),
      .rem_dec_en     (rem_dec_en),
      .rem_dec_data   (rem_dec_data),
      .rsp_valid      (rsp_valid),
      .rsp_ran        (rsp_ran),
      .rsp_process_id (rsp_process_id),
      .rsp_finished   (rsp_finished),
      .rsp_wait_time  (rsp_wait_time),
      .rsp_turnaround (rsp_turnaround),
      .rsp_all_done   (rsp_all_done),
      .rsp_tick_time  (rsp_tick_time)
   );

endmodule : shortest_remaining_time_scheduler

`default_nettype wire

FILE: tb/sv/shortest_remaining_time_scheduler_tb.sv
// Self-checking testbench for the shortest-remaining-time scheduler: load and tick words
// are driven in bursts, and every tick report is checked against a scheduling model.
// Depends on srtf_pkg and the shortest_remaining_time_scheduler RTL.
`timescale 1ns / 100ps

module shortest_remaining_time_scheduler_tb;
   import srtf_pkg::*;

   localparam int SLOTS = MAX_PROCESSES_DEF;
   localparam logic [OUT_BITS-1:0] TIME_TOP = '1;
   // longest tick is a full scan of 16 slots then drain, decide and finish; leave a wide margin
   localparam int SETTLE_CYCLES = 40;
   localparam int DRAIN_LIMIT = 5000;
   localparam int RANDOM_PHASES = 8;
   localparam int PHASE_WORDS = 180;

   typedef struct {
      logic [OPCODE_BITS-1:0] opcode;
      logic [SLOT_BITS-1:0]   slot;
      logic [FIELD_BITS-1:0]  arrival;
      logic [FIELD_BITS-1:0]  burst;
   } sched_word_type;

   typedef struct packed {
      logic                ran;
      logic [PID_BITS-1:0] pid;
      logic                finished;
      logic [OUT_BITS-1:0] wait_time;
      logic [OUT_BITS-1:0] turnaround;
      logic                all_done;
      logic [OUT_BITS-1:0] tick_time;
   } tick_report_type;

   logic                   clock;
   logic                   reset = 1'b1;
   logic                   start = 1'b0;
   logic                   busy;
   logic [OPCODE_BITS-1:0] req_opcode = OP_LOAD;
   logic [SLOT_BITS-1:0]   req_slot = '0;
   logic [FIELD_BITS-1:0]  req_arrival = '0;
   logic [FIELD_BITS-1:0]  req_burst = '0;
   logic                   csr_wr_en = 1'b0;
   logic [COUNT_BITS-1:0]  csr_wr_data = '0;
   logic                   rsp_valid;
   logic                   rsp_ran;
   logic [PID_BITS-1:0]    rsp_process_id;
   logic                   rsp_finished;
   logic [OUT_BITS-1:0]    rsp_wait_time;
   logic [OUT_BITS-1:0]    rsp_turnaround;
   logic                   rsp_all_done;
   logic [OUT_BITS-1:0]    rsp_tick_time;

   shortest_remaining_time_scheduler u_top (
      .clock          (clock),
      .reset          (reset),
      .start          (start),
      .busy           (busy),
      .req_opcode     (req_opcode),
      .req_slot       (req_slot),
      .req_arrival    (req_arrival),
      .req_burst      (req_burst),
      .csr_wr_en      (csr_wr_en),
      .csr_wr_data    (csr_wr_data),
      .rsp_valid      (rsp_valid),
      .rsp_ran        (rsp_ran),
      .rsp_process_id (rsp_process_id),
      .rsp_finished   (rsp_finished),
      .rsp_wait_time  (rsp_wait_time),
      .rsp_turnaround (rsp_turnaround),
      .rsp_all_done   (rsp_all_done),
      .rsp_tick_time  (rsp_tick_time)
   );

   // scheduler state as the testbench sees it
   logic [FIELD_BITS-1:0] slot_arrival [SLOTS];
   logic [FIELD_BITS-1:0] slot_burst [SLOTS];
   logic [FIELD_BITS-1:0] slot_left [SLOTS];
   logic [OUT_BITS-1:0]   sched_now;
   logic [COUNT_BITS-1:0] active_count;

   sched_word_type  words_to_send [$];
   tick_report_type reports_due [$];

   bit quiet_sender = 1'b0;
   int burst_left = 0;
   int gap_left = 0;

   int n_words = 0;
   int n_ticks = 0;
   int n_finished = 0;
   int n_idle = 0;
   int n_all_done = 0;
   int n_mismatch = 0;

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   initial begin
      #20_000_000;
      $display("shortest_remaining_time_scheduler_tb failed");
      $finish;
   end

   function automatic tick_report_type next_tick_report();
      tick_report_type r;
      int              active;
      int              best;
      int              i;
      bit              any_left;
      bit              found;
      logic [16:0]     completion;
      logic [16:0]     tat;
      logic [16:0]     wt;
      r = '0;
      active = (active_count > SLOTS) ? SLOTS : active_count;
      any_left = 1'b0;
      found = 1'b0;
      best = 0;
      for (i = 0; i < active; i++) begin
         if (slot_left[i] != 0) begin
            any_left = 1'b1;
            if (slot_arrival[i] <= sched_now &&
                (!found || slot_left[i] < slot_left[best])) begin
               found = 1'b1;
               best = i;
            end
         end
      end
      r.tick_time = sched_now;
      // nothing left anywhere: report and leave the clock alone
      if (!any_left) begin
         r.all_done = 1'b1;
         return r;
      end
      if (found) begin
         r.ran = 1'b1;
         r.pid = PID_BITS'(best + 1);
         slot_left[best] = slot_left[best] - 1'b1;
         if (slot_left[best] == 0) begin
            completion = {1'b0, sched_now} + 17'd1;
            tat = completion - {1'b0, slot_arrival[best]};
            // a reload can pull the clock back, so clamp a negative wait to zero
            wt = (tat >= {1'b0, slot_burst[best]}) ? tat - {1'b0, slot_burst[best]} : '0;
            r.finished = 1'b1;
            r.wait_time = wt[16] ? TIME_TOP : wt[15:0];
            r.turnaround = tat[16] ? TIME_TOP : tat[15:0];
         end
      end
      if (sched_now != TIME_TOP) sched_now = sched_now + 1'b1;
      return r;
   endfunction

   task automatic check_report();
      tick_report_type got;
      tick_report_type want;
      got = {rsp_ran, rsp_process_id, rsp_finished, rsp_wait_time, rsp_turnaround,
             rsp_all_done, rsp_tick_time};
      if (reports_due.size() == 0) begin
         n_mismatch++;
         if (n_mismatch <= 10)
            $display("%0t: result word with no tick outstanding: ran=%0d pid=%0d t=%0d",
                     $realtime, got.ran, got.pid, got.tick_time);
         return;
      end
      want = reports_due.pop_front();
      if (got !== want) begin
         n_mismatch++;
         if (n_mismatch <= 10)
            $display({"%0t: tick report mismatch\n",
                      "   want ran=%0d pid=%0d fin=%0d wait=%0d tat=%0d done=%0d t=%0d\n",
                      "   got  ran=%0d pid=%0d fin=%0d wait=%0d tat=%0d done=%0d t=%0d"},
                     $realtime,
                     want.ran, want.pid, want.finished, want.wait_time, want.turnaround,
                     want.all_done, want.tick_time,
                     got.ran, got.pid, got.finished, got.wait_time, got.turnaround,
                     got.all_done, got.tick_time);
      end
      if (want.finished) n_finished++;
      if (want.all_done) n_all_done++;
      else if (!want.ran) n_idle++;
   endtask

   // sample at the rising edge: register writes, result words, then accepted words
   always @(posedge clock) begin : sample_outputs
      sched_word_type w;
      int             i;
      if (reset) begin
         for (i = 0; i < SLOTS; i++) begin
            slot_arrival[i] = '0;
            slot_burst[i] = '0;
            slot_left[i] = '0;
         end
         sched_now = '0;
         active_count = '0;
      end else begin
         if (csr_wr_en) active_count = csr_wr_data;
         if (rsp_valid) check_report();
         if (start && !busy) begin
            w = words_to_send.pop_front();
            n_words++;
            if (w.opcode == OP_TICK) begin
               reports_due.push_back(next_tick_report());
               n_ticks++;
            end else begin
               slot_arrival[w.slot] = w.arrival;
               slot_burst[w.slot] = w.burst;
               slot_left[w.slot] = w.burst;
               sched_now = '0;
            end
         end
      end
   end

   // present the head of the queue in bursts, with gaps between them
   always @(negedge clock) begin
      if (reset || gap_left != 0 || words_to_send.size() == 0) begin
         start <= 1'b0;
         if (!reset && gap_left != 0) gap_left--;
      end else begin
         start <= 1'b1;
         req_opcode <= words_to_send[0].opcode;
         req_slot <= words_to_send[0].slot;
         req_arrival <= words_to_send[0].arrival;
         req_burst <= words_to_send[0].burst;
         if (burst_left != 0) begin
            burst_left--;
         end else begin
            burst_left = $urandom_range(1, 40);
            gap_left = (quiet_sender || $urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 24);
         end
      end
   end

   task automatic push_word(logic [OPCODE_BITS-1:0] op, int slot, int arrival, int burst);
      sched_word_type w;
      w.opcode = op;
      w.slot = SLOT_BITS'(slot);
      w.arrival = FIELD_BITS'(arrival);
      w.burst = FIELD_BITS'(burst);
      words_to_send.push_back(w);
   endtask

   task automatic write_count(int value);
      @(negedge clock);
      csr_wr_en = 1'b1;
      csr_wr_data = COUNT_BITS'(value);
      @(negedge clock);
      csr_wr_en = 1'b0;
   endtask

   // hold until the queue is sent and every report is in, then let the block go quiet
   task automatic drain_and_settle();
      int waited;
      while (words_to_send.size() != 0) @(negedge clock);
      waited = 0;
      while (reports_due.size() != 0 && waited < DRAIN_LIMIT) begin
         @(negedge clock);
         waited++;
      end
      if (reports_due.size() != 0) begin
         n_mismatch += reports_due.size();
         $display("%0t: %0d tick reports never arrived", $realtime, reports_due.size());
         reports_due.delete();
      end
      repeat (SETTLE_CYCLES) @(negedge clock);
      while (busy) @(negedge clock);
   endtask

   task automatic push_random_load(int count_val);
      int lim;
      int slot;
      int arrival;
      int burst;
      lim = (count_val > SLOTS) ? SLOTS : count_val;
      if (lim > 0 && $urandom_range(0, 4) != 0) slot = $urandom_range(0, lim - 1);
      else slot = $urandom_range(0, SLOTS - 1);
      case ($urandom_range(0, 9))
         0: arrival = $urandom_range(0, 65535);
         1: arrival = 0;
         default: arrival = $urandom_range(0, 15);
      endcase
      case ($urandom_range(0, 19))
         0, 1: burst = 0;
         2: burst = $urandom_range(0, 65535);
         3, 4, 5: burst = $urandom_range(7, 60);
         default: burst = $urandom_range(1, 6);
      endcase
      push_word(OP_LOAD, slot, arrival, burst);
   endtask

   // a run is a handful of loads then a stretch of ticks, with the odd reload mid-run
   task automatic fill_random_phase(int count_val, int target);
      int pushed;
      int k;
      pushed = 0;
      while (pushed < target) begin
         k = $urandom_range(1, 6);
         repeat (k) begin
            push_random_load(count_val);
            pushed++;
         end
         k = $urandom_range(4, 48);
         repeat (k) begin
            if ($urandom_range(0, 19) == 0) push_random_load(count_val);
            else push_word(OP_TICK, $urandom_range(0, SLOTS - 1), $urandom_range(0, 65535),
                           $urandom_range(0, 65535));
            pushed++;
         end
      end
   endtask

   initial begin : stimulus
      int s;
      int p;
      int count_plan [RANDOM_PHASES];
      count_plan = '{16, 1, 31, 5, 0, 16, 3, 9};
      count_plan[RANDOM_PHASES-1] = $urandom_range(2, 15);
      reset = 1'b1;
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // write every slot once so no table entry is ever read unwritten
      for (s = 0; s < SLOTS; s++) push_word(OP_LOAD, s, 0, 0);
      // count still zero from reset: the tick reports all done
      push_word(OP_TICK, 0, 0, 0);
      drain_and_settle();

      // count above the slot total acts as all slots
      write_count(31);
      push_word(OP_LOAD, 4, 1, 1);
      push_word(OP_TICK, 0, 0, 0);
      push_word(OP_TICK, 0, 0, 0);
      // tie between slots 7 and 15 goes to the lower one
      push_word(OP_LOAD, 15, 0, 2);
      push_word(OP_LOAD, 7, 0, 2);
      push_word(OP_LOAD, 0, 3, 1);
      repeat (3) push_word(OP_TICK, 0, 0, 0);
      // reload pulls the clock back, so slot 15 finishes with a negative wait
      push_word(OP_LOAD, 1, 0, 4);
      repeat (7) push_word(OP_TICK, 0, 0, 0);
      drain_and_settle();

      // ticks back to back with no gaps until both slots finish and all done shows
      write_count(2);
      quiet_sender = 1'b1;
      push_word(OP_LOAD, 0, 0, 40);
      push_word(OP_LOAD, 1, 0, 1);
      repeat (48) push_word(OP_TICK, 15, 65535, 65535);
      drain_and_settle();
      quiet_sender = 1'b0;

      for (p = 0; p < RANDOM_PHASES; p++) begin
         write_count(count_plan[p]);
         fill_random_phase(count_plan[p], PHASE_WORDS);
         drain_and_settle();
      end

      $display("run covered %0d words and %0d ticks: %0d completions, %0d idle, %0d all done",
               n_words, n_ticks, n_finished, n_idle, n_all_done);
      $display("slot counts from 0 to 31, back-to-back ticks and reloads mid-run; %0d mismatches",
               n_mismatch);
      if (n_mismatch == 0) begin
         $display("shortest_remaining_time_scheduler_tb passed");
      end else begin
         $display("shortest_remaining_time_scheduler_tb failed");
      end
      $finish;
   end

endmodule
